// ===== rtl/coordinate_range_to_rgb_defines.svh =====
// assertion macros used by the coordinate range to rgb checker
`ifndef COORDINATE_RANGE_TO_RGB_DEFINES_SVH
`define COORDINATE_RANGE_TO_RGB_DEFINES_SVH

// clocked property, switched off while reset is asserted
`define CRGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked property that also holds while reset is asserted
`define CRGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/crgb_pkg.sv =====
// shared types and constants of the coordinate range to rgb block
`timescale 1ns / 1ps

package crgb_pkg;

  // command carried in tuser
  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_COLOR   = 2'd2
  } cmd_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned COLOR_BITS = 8;
  localparam int unsigned STEP_CNT_W = 3;
  localparam logic [COLOR_BITS-1:0] COLOR_FULL = 8'd255;
  localparam logic [STEP_CNT_W-1:0] STEP_LAST  = 3'd7;

endpackage

// ===== rtl/coordinate_range_to_rgb.sv =====
// min-max normalization of 3-d coordinates to rgb bytes, radix-2 serial dividers
//
//  channel  | direction | tdata                         | tuser
//  ---------+-----------+-------------------------------+-------------
//  s_axis   | in        | x_coord, y_coord, z_coord     | command
//  m_axis   | out       | red, green, blue              | -
//
// clear and measure transactions complete in the idle state and produce no output.
// a color transaction passes these steps from acceptance to the next acceptance:
// registering the offsets, setting up the dividend, eight radix-2 steps of
// the three per-axis dividers (one quotient bit each per cycle), and loading
// the output register, which waits while a held result sees m_axis_tready low.
// reset clears the range registers to zero and the output valid.
`timescale 1ns / 1ps

module coordinate_range_to_rgb #(
  parameter int unsigned COORD_WIDTH = 16,
  localparam int unsigned IN_DATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,  // x_coord, y_coord, z_coord, zero fill
  input  logic [1:0]           s_axis_tuser,  // command
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [23:0]          m_axis_tdata   // red, green, blue
);

  localparam int unsigned NA = crgb_pkg::NUM_AXES;
  localparam int unsigned CB = crgb_pkg::COLOR_BITS;

  // control state
  crgb_pkg::state_e                        state_q, state_d;
  logic [crgb_pkg::STEP_CNT_W-1:0]         cnt_q, cnt_d;
  logic                                    m_valid_q, m_valid_d;
  logic                                    accept;
  crgb_pkg::cmd_e                          cmd;

  // per-axis range
  logic signed [COORD_WIDTH-1:0] coord [NA];
  logic signed [COORD_WIDTH-1:0] lo_q [NA], lo_d [NA];
  logic signed [COORD_WIDTH-1:0] hi_q [NA], hi_d [NA];

  // per-axis divider datapath
  logic signed [COORD_WIDTH:0]   off_q [NA], off_d [NA];
  logic [COORD_WIDTH-1:0]        span_q [NA], span_d [NA];
  logic [COORD_WIDTH-1:0]        rem_q [NA], rem_d [NA];
  logic [CB-1:0]                 sh_q [NA], sh_d [NA];
  logic                          zero_q [NA], zero_d [NA];
  logic                          sat_q [NA], sat_d [NA];
  logic [CB-1:0]                 color_q [NA], color_d [NA];

  // per-axis temporaries
  logic [COORD_WIDTH:0]          span_full [NA];
  logic [COORD_WIDTH+CB-1:0]     prod [NA];
  logic [COORD_WIDTH+1:0]        trial [NA];

  // unpack coordinates
  assign coord[0] = s_axis_tdata[COORD_WIDTH-1:0];
  assign coord[1] = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign coord[2] = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];

  assign cmd           = crgb_pkg::cmd_e'(s_axis_tuser);
  assign s_axis_tready = (state_q == crgb_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {color_q[2], color_q[1], color_q[0]};

  // sequencer and per-axis datapath
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    for (int a = 0; a < NA; a++) begin
      lo_d[a]      = lo_q[a];
      hi_d[a]      = hi_q[a];
      off_d[a]     = off_q[a];
      span_d[a]    = span_q[a];
      rem_d[a]     = rem_q[a];
      sh_d[a]      = sh_q[a];
      zero_d[a]    = zero_q[a];
      sat_d[a]     = sat_q[a];
      color_d[a]   = color_q[a];
      span_full[a] = {hi_q[a][COORD_WIDTH-1], hi_q[a]} - {lo_q[a][COORD_WIDTH-1], lo_q[a]};
      prod[a]      = {off_q[a][COORD_WIDTH-1:0], {CB{1'b0}}}
                   - {{CB{1'b0}}, off_q[a][COORD_WIDTH-1:0]};
      trial[a]     = {1'b0, rem_q[a], sh_q[a][CB-1]} - {2'b00, span_q[a]};
    end

    case (state_q)
      crgb_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd)
            crgb_pkg::CMD_CLEAR: begin
              for (int a = 0; a < NA; a++) begin
                lo_d[a] = '0;
                hi_d[a] = '0;
              end
            end
            crgb_pkg::CMD_MEASURE: begin
              for (int a = 0; a < NA; a++) begin
                if (coord[a] < lo_q[a]) lo_d[a] = coord[a];
                if (coord[a] > hi_q[a]) hi_d[a] = coord[a];
              end
            end
            crgb_pkg::CMD_COLOR: begin
              // offset from the minimum and width of the range
              for (int a = 0; a < NA; a++) begin
                off_d[a]  = {coord[a][COORD_WIDTH-1], coord[a]}
                          - {lo_q[a][COORD_WIDTH-1], lo_q[a]};
                span_d[a] = span_full[a][COORD_WIDTH-1:0];
              end
              state_d = crgb_pkg::ST_PREP;
            end
            default: ;
          endcase
        end
      end

      crgb_pkg::ST_PREP: begin
        // special cases and dividend off * 255, split into remainder and shift bits
        for (int a = 0; a < NA; a++) begin
          zero_d[a] = (span_q[a] == '0) || off_q[a][COORD_WIDTH] || (off_q[a] == '0);
          sat_d[a]  = (off_q[a] >= $signed({1'b0, span_q[a]}));
          rem_d[a]  = prod[a][COORD_WIDTH+CB-1:CB];
          sh_d[a]   = prod[a][CB-1:0];
        end
        cnt_d   = '0;
        state_d = crgb_pkg::ST_DIV;
      end

      crgb_pkg::ST_DIV: begin
        // one restoring step per axis, quotient bits enter from the right
        for (int a = 0; a < NA; a++) begin
          if (!trial[a][COORD_WIDTH+1]) begin
            rem_d[a] = trial[a][COORD_WIDTH-1:0];
            sh_d[a]  = {sh_q[a][CB-2:0], 1'b1};
          end else begin
            rem_d[a] = {rem_q[a][COORD_WIDTH-2:0], sh_q[a][CB-1]};
            sh_d[a]  = {sh_q[a][CB-2:0], 1'b0};
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == crgb_pkg::STEP_LAST) state_d = crgb_pkg::ST_DONE;
      end

      crgb_pkg::ST_DONE: begin
        // load the output register once it is free
        if (!m_valid_q || m_axis_tready) begin
          for (int a = 0; a < NA; a++) begin
            if (zero_q[a])     color_d[a] = '0;
            else if (sat_q[a]) color_d[a] = crgb_pkg::COLOR_FULL;
            else               color_d[a] = sh_q[a];
          end
          m_valid_d = 1'b1;
          state_d   = crgb_pkg::ST_IDLE;
        end
      end

      default: state_d = crgb_pkg::ST_IDLE;
    endcase
  end

  // control and range registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= crgb_pkg::ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        lo_q[a] <= '0;
        hi_q[a] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      for (int a = 0; a < NA; a++) begin
        lo_q[a] <= lo_d[a];
        hi_q[a] <= hi_d[a];
      end
    end
  end

  // divider and output payload registers
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NA; a++) begin
      off_q[a]   <= off_d[a];
      span_q[a]  <= span_d[a];
      rem_q[a]   <= rem_d[a];
      sh_q[a]    <= sh_d[a];
      zero_q[a]  <= zero_d[a];
      sat_q[a]   <= sat_d[a];
      color_q[a] <= color_d[a];
    end
  end

endmodule

// ===== rtl/crgb_chk.sv =====
// port-level checker for the coordinate range to rgb block, with its bind
`timescale 1ns / 1ps
`include "coordinate_range_to_rgb_defines.svh"

module crgb_chk #(
  parameter int unsigned COORD_WIDTH = 16,
  localparam int unsigned IN_DATA_W  = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [IN_DATA_W-1:0] s_axis_tdata,  // x_coord, y_coord, z_coord, zero fill
  input logic [1:0]           s_axis_tuser,  // command
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [23:0]          m_axis_tdata   // red, green, blue
);

  logic s_txn;
  logic s_color;

  assign s_txn   = s_axis_tvalid && s_axis_tready;
  assign s_color = (s_axis_tuser == crgb_pkg::CMD_COLOR);

  // a stalled result holds
  `CRGB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output changed while stalled")

  // a color transaction occupies the divider
  `CRGB_ASSERT(a_color_busy, s_txn && s_color |=> !s_axis_tready, "input ready right after color transaction")

  // clear and measure keep the input ready
  `CRGB_ASSERT(a_measure_fast, s_txn && !s_color |=> s_axis_tready, "input not ready after clear or measure")

  // a new result only appears while the divider is busy
  `CRGB_ASSERT(a_out_source, $rose(m_axis_tvalid) |-> $past(!s_axis_tready), "output appeared without a division")

  // reset holds the output empty
  `CRGB_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !m_axis_tvalid, "output valid during reset")

endmodule

bind coordinate_range_to_rgb crgb_chk #(
  .COORD_WIDTH(COORD_WIDTH)
) u_crgb_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tuser (s_axis_tuser),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
